// ===== rtl/bsc_pkg.sv =====
// shared types and constants for the barometric compensation block
`timescale 1ns / 1ps
package bsc_pkg;

  typedef struct packed {
    logic        operation;
    logic [18:0] raw_sample;
  } bsc_in_t;

  typedef struct packed {
    logic        result_kind;
    logic [31:0] value;
    logic        divide_error;
  } bsc_out_t;

  localparam logic OpTemp  = 1'b0;
  localparam logic OpPress = 1'b1;

  localparam logic [1:0] RegTempCal  = 2'd0;
  localparam logic [1:0] RegPressA   = 2'd1;
  localparam logic [1:0] RegPressB   = 2'd2;
  localparam logic [1:0] RegOss      = 2'd3;

  // datapath micro-operations
  typedef enum logic [4:0] {
    UopT0, UopT1, UopT2, UopT3,
    UopP0, UopP1, UopP2, UopP3, UopP4, UopP5, UopP6, UopP7, UopP8,
    UopP9, UopP10, UopP11, UopP12, UopP13, UopP14, UopP15, UopP16
  } bsc_uop_e;

  typedef struct packed {
    logic     load;
    logic     exec;
    bsc_uop_e uop;
    logic     div_start;
  } bsc_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_zero;
  } bsc_sts_t;

endpackage

// ===== rtl/bsc_div.sv =====
// restoring unsigned 32-bit divider, one quotient bit per cycle
`timescale 1ns / 1ps
module bsc_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        busy_o,
  output logic [31:0] quot_o
);
  logic [31:0] quot_q, quot_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] dsr_q, dsr_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [32:0] trial;

  assign trial = {rem_q[31:0], quot_q[31]};

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
      cnt_d  = 6'd32;
    end else if (cnt_q != '0) begin
      if (trial >= {1'b0, dsr_q}) begin
        rem_d  = trial - {1'b0, dsr_q};
        quot_d = {quot_q[30:0], 1'b1};
      end else begin
        rem_d  = trial;
        quot_d = {quot_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = quot_q;

endmodule

// ===== rtl/bsc_datapath.sv =====
// compensation datapath: shared multiplier, accumulator registers and divider
`timescale 1ns / 1ps
module bsc_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bsc_pkg::bsc_cmd_t cmd_i,
  output bsc_pkg::bsc_sts_t sts_o,
  input  bsc_pkg::bsc_in_t  item_i,
  input  logic [63:0]       temp_cal_i,
  input  logic [47:0]       cal_a_i,
  input  logic [47:0]       cal_b_i,
  input  logic [1:0]        oss_i,
  output logic [31:0]       value_o,
  output logic              err_o
);
  import bsc_pkg::*;

  logic [18:0] raw_q;
  logic [31:0] b5_q, b5_d;
  logic [31:0] r0_q, r0_d, r1_q, r1_d, r2_q, r2_d, r3_q, r3_d;
  logic [31:0] mul_a, mul_b, prod;
  logic [31:0] val_q, val_d;
  logic        err_q, err_d;
  logic [31:0] div_n, div_dv, quot;
  logic        div_busy;
  logic        neg_q, neg_d;

  logic [31:0] ac5, ac6, mc, md, ac1, ac2, ac3, ac4, b1, b2, raw32;

  function automatic logic [31:0] sx(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] n);
    return 32'($signed(v) >>> n);
  endfunction

  assign ac5 = {16'd0, temp_cal_i[15:0]};
  assign ac6 = {16'd0, temp_cal_i[31:16]};
  assign mc  = sx(temp_cal_i[47:32]);
  assign md  = sx(temp_cal_i[63:48]);
  assign ac1 = sx(cal_a_i[15:0]);
  assign ac2 = sx(cal_a_i[31:16]);
  assign ac3 = sx(cal_a_i[47:32]);
  assign ac4 = {16'd0, cal_b_i[15:0]};
  assign b1  = sx(cal_b_i[31:16]);
  assign b2  = sx(cal_b_i[47:32]);
  assign raw32 = {13'd0, raw_q};

  // single shared 32x32 low-word multiplier
  assign prod = 32'(mul_a * mul_b);

  always_comb begin
    mul_a  = r0_q;
    mul_b  = r1_q;
    r0_d   = r0_q;
    r1_d   = r1_q;
    r2_d   = r2_q;
    r3_d   = r3_q;
    b5_d   = b5_q;
    val_d  = val_q;
    err_d  = err_q;
    neg_d  = neg_q;
    div_n  = r0_q;
    div_dv = r1_q;
    if (cmd_i.exec) begin
      case (cmd_i.uop)
        UopT0: begin
          mul_a = raw32 - ac6;
          mul_b = ac5;
          r0_d  = asr(prod, 5'd15);            // x1
          err_d = 1'b0;
        end
        UopT1: begin
          r1_d = r0_q + md;                     // den
          r2_d = mc << 11;
        end
        UopT2: begin
          // signed division by magnitudes
          neg_d = r2_q[31] ^ r1_q[31];
          div_n = r2_q[31] ? 32'(-r2_q) : r2_q;
          div_dv = r1_q[31] ? 32'(-r1_q) : r1_q;
          if (r1_q == '0) begin
            err_d = 1'b1;
            val_d = '0;
          end
        end
        UopT3: begin
          if (!err_q) begin
            b5_d  = r0_q + (neg_q ? 32'(-quot) : quot);
            val_d = asr(r0_q + (neg_q ? 32'(-quot) : quot) + 32'd8, 5'd4);
          end
        end
        UopP0: begin
          err_d = 1'b0;
          r0_d  = b5_q - 32'd4000;              // b6
          mul_a = b5_q - 32'd4000;
          mul_b = b5_q - 32'd4000;
          r1_d  = asr(prod, 5'd12);             // sq
        end
        UopP1: begin
          mul_a = b2;
          mul_b = r1_q;
          r2_d  = asr(prod, 5'd11);
        end
        UopP2: begin
          mul_a = ac2;
          mul_b = r0_q;
          r2_d  = r2_q + asr(prod, 5'd11);      // x3
        end
        UopP3: begin
          r2_d = asr(((ac1 << 2) + r2_q << oss_i) + 32'd2, 5'd2);  // b3
        end
        UopP4: begin
          mul_a = ac3;
          mul_b = r0_q;
          r3_d  = asr(prod, 5'd13);
        end
        UopP5: begin
          mul_a = b1;
          mul_b = r1_q;
          r3_d  = asr(r3_q + asr(prod, 5'd16) + 32'd2, 5'd2);
        end
        UopP6: begin
          mul_a = ac4;
          mul_b = r3_q + 32'd32768;
          r3_d  = prod >> 15;                   // b4
        end
        UopP7: begin
          mul_a = raw32 - r2_q;
          mul_b = 32'd50000 >> oss_i;
          r2_d  = prod;                         // b7
        end
        UopP8: begin
          neg_d  = r2_q[31];
          div_n  = r2_q[31] ? r2_q : (r2_q << 1);
          div_dv = r3_q;
          if (r3_q == '0) begin
            err_d = 1'b1;
            val_d = '0;
          end
        end
        UopP9: begin
          r0_d = neg_q ? (quot << 1) : quot;    // p
        end
        UopP10: begin
          mul_a = asr(r0_q, 5'd8);
          mul_b = asr(r0_q, 5'd8);
          r1_d  = prod;
        end
        UopP11: begin
          mul_a = r1_q;
          mul_b = 32'd3038;
          r1_d  = asr(prod, 5'd16);
        end
        UopP12: begin
          mul_a = 32'd7357;
          mul_b = r0_q;
          r2_d  = asr(32'd0 - prod, 5'd16);
        end
        UopP13: begin
          if (!err_q) begin
            val_d = r0_q + asr(r1_q + r2_q + 32'd3791, 5'd4);
          end
        end
        default: begin
        end
      endcase
    end
  end

  bsc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_n),
    .divisor_i  (div_dv),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b5_q <= '0;
    end else begin
      b5_q <= b5_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      raw_q <= item_i.raw_sample;
    end
    r0_q  <= r0_d;
    r1_q  <= r1_d;
    r2_q  <= r2_d;
    r3_q  <= r3_d;
    val_q <= val_d;
    err_q <= err_d;
    neg_q <= neg_d;
  end

  assign sts_o.div_busy = div_busy;
  assign sts_o.div_zero = err_q;
  assign value_o = val_q;
  assign err_o   = err_q;

endmodule

// ===== rtl/bsc_ctrl.sv =====
// sequencer stepping the datapath through the compensation micro-operations
`timescale 1ns / 1ps
module bsc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              op_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              kind_o,
  output bsc_pkg::bsc_cmd_t cmd_o,
  input  bsc_pkg::bsc_sts_t sts_i
);
  import bsc_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StRun, StDivWait, StDone
  } state_e;

  state_e   state_q;
  bsc_uop_e uop_q;
  logic     kind_q;
  logic     out_valid_q;

  logic accept;
  assign accept = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == StIdle) && !out_valid_q;

  always_comb begin
    cmd_o.load      = accept;
    cmd_o.exec      = (state_q == StRun);
    cmd_o.uop       = uop_q;
    // divider starts in the cycle that presents its operands
    cmd_o.div_start = (state_q == StRun) && (uop_q inside {UopT2, UopP8});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      uop_q       <= UopT0;
      kind_q      <= OpTemp;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (accept) begin
            kind_q  <= op_i;
            uop_q   <= (op_i == OpPress) ? UopP0 : UopT0;
            state_q <= StRun;
          end
        end
        StRun: begin
          case (uop_q)
            UopT2, UopP8: begin
              state_q <= StDivWait;
            end
            UopT3, UopP13: state_q <= StDone;
            default: uop_q <= bsc_uop_e'(uop_q + 5'd1);
          endcase
        end
        StDivWait: begin
          if (!sts_i.div_busy) begin
            uop_q   <= bsc_uop_e'(uop_q + 5'd1);
            state_q <= StRun;
          end
        end
        StDone: begin
          out_valid_q <= 1'b1;
          state_q     <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !in_ready_o) else $error("item accepted while busy");
  a_done_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone) |=> out_valid_q) else $error("result not presented");
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDivWait && sts_i.div_busy) |=> (state_q == StDivWait))
    else $error("left divide wait early");

endmodule

// ===== rtl/barometric_sensor_compensation_top.sv =====
// top level of the barometric compensation block with its register port
`timescale 1ns / 1ps
// usage:
// - input channel in_valid_i/in_ready_o carries operation and raw_sample;
//   operation 0 compensates a temperature, 1 a pressure using the stored b5
// - output channel out_valid_o/out_ready_i returns result_kind, value and
//   divide_error, one result per input transaction
// - calibration words and oversampling are written through the apb port while
//   idle: temperature_cal at 0x0, pressure_cal_a at 0x8, pressure_cal_b at 0x10,
//   oversampling at 0x18
// - one item at a time: the result is offered once the micro-operation sequence
//   over the shared multiplier and the restoring divider has run; a pressure
//   runs more micro-operations than a temperature
// - the next item is taken the cycle after the previous result has been taken;
//   a stalled receiver holds the result steady and the input stays not ready
// - reset clears the calibration, stored b5 and sets oversampling to 3
module barometric_sensor_compensation_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bsc_pkg::bsc_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bsc_pkg::bsc_out_t out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);
  import bsc_pkg::*;

  logic [63:0] tcal_q;
  logic [47:0] cal_a_q, cal_b_q;
  logic [1:0]  oss_q;
  bsc_cmd_t    cmd;
  bsc_sts_t    sts;
  logic [31:0] value;
  logic        err;
  logic        kind;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tcal_q  <= '0;
      cal_a_q <= '0;
      cal_b_q <= '0;
      oss_q   <= 2'd3;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        RegTempCal: tcal_q  <= pwdata;
        RegPressA:  cal_a_q <= pwdata[47:0];
        RegPressB:  cal_b_q <= pwdata[47:0];
        RegOss:     oss_q   <= pwdata[1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegTempCal: prdata = tcal_q;
      RegPressA:  prdata = {16'd0, cal_a_q};
      RegPressB:  prdata = {16'd0, cal_b_q};
      RegOss:     prdata = {62'd0, oss_q};
      default:    prdata = '0;
    endcase
  end

  bsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .op_i        (in_data_i.operation),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  bsc_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .item_i     (in_data_i),
    .temp_cal_i (tcal_q),
    .cal_a_i    (cal_a_q),
    .cal_b_i    (cal_b_q),
    .oss_i      (oss_q),
    .value_o    (value),
    .err_o      (err)
  );

  assign out_data_o.result_kind  = kind;
  assign out_data_o.value        = value;
  assign out_data_o.divide_error = err;

endmodule

// ===== test/bsc_checker.sv =====
// checker for the barometric compensation block: predicts and compares results
`timescale 1ns / 1ps
module bsc_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  bsc_pkg::bsc_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  bsc_pkg::bsc_out_t out_data_i,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [4:0]        paddr_i,
  input  logic [63:0]       pwdata_i,
  input  logic              pready_i,
  output int                fail_count_o,
  output int                pending_o
);
  import bsc_pkg::*;

  logic [63:0] temp_cal;
  logic [47:0] press_a;
  logic [47:0] press_b;
  logic [1:0]  oss;
  logic [31:0] b5_held;
  bsc_out_t    expected_q[$];

  function automatic logic [31:0] sext16(logic [15:0] w);
    return {{16{w[15]}}, w};
  endfunction

  function automatic logic [31:0] sra(logic [31:0] v, int n);
    return $unsigned($signed(v) >>> n);
  endfunction

  // compensation of one transaction; updates the held b5 on a good temperature
  function automatic bsc_out_t compensate(bsc_in_t item);
    bsc_out_t r;
    logic [31:0] raw, x1, x2, x3, den, b5, b6, sq, b3, b4, b7, p;
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, mc, md, b1, b2;
    longint q;
    raw = {13'b0, item.raw_sample};
    r.result_kind = item.operation;
    r.value = '0;
    r.divide_error = 1'b0;
    if (item.operation == OpTemp) begin
      ac5 = {16'b0, temp_cal[15:0]};
      ac6 = {16'b0, temp_cal[31:16]};
      mc = sext16(temp_cal[47:32]);
      md = sext16(temp_cal[63:48]);
      x1 = sra((raw - ac6) * ac5, 15);
      den = x1 + md;
      if (den == 0) begin
        r.divide_error = 1'b1;
      end else begin
        q = longint'($signed(mc << 11)) / longint'($signed(den));
        b5 = x1 + q[31:0];
        b5_held = b5;
        r.value = sra(b5 + 32'd8, 4);
      end
    end else begin
      ac1 = sext16(press_a[15:0]);
      ac2 = sext16(press_a[31:16]);
      ac3 = sext16(press_a[47:32]);
      ac4 = {16'b0, press_b[15:0]};
      b1 = sext16(press_b[31:16]);
      b2 = sext16(press_b[47:32]);
      b6 = b5_held - 32'd4000;
      sq = sra(b6 * b6, 12);
      x1 = sra(b2 * sq, 11);
      x2 = sra(ac2 * b6, 11);
      x3 = x1 + x2;
      b3 = sra(((ac1 * 32'd4 + x3) << oss) + 32'd2, 2);
      x1 = sra(ac3 * b6, 13);
      x2 = sra(b1 * sq, 16);
      x3 = sra(x1 + x2 + 32'd2, 2);
      b4 = (ac4 * (x3 + 32'd32768)) >> 15;
      b7 = (raw - b3) * (32'd50000 >> oss);
      if (b4 == 0) begin
        r.divide_error = 1'b1;
      end else begin
        if (b7 < 32'h8000_0000) p = (b7 << 1) / b4;
        else p = (b7 / b4) << 1;
        x1 = sra(p, 8) * sra(p, 8);
        x1 = sra(x1 * 32'd3038, 16);
        x2 = sra(32'd0 - 32'd7357 * p, 16);
        p = p + sra(x1 + x2 + 32'd3791, 4);
        r.value = p;
      end
    end
    return r;
  endfunction

  assign pending_o = expected_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    bsc_out_t want;
    if (!rst_ni) begin
      temp_cal <= '0;
      press_a <= '0;
      press_b <= '0;
      oss <= 2'd3;
      b5_held = '0;
      fail_count_o <= 0;
      expected_q.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[4:3])
          RegTempCal: temp_cal <= pwdata_i;
          RegPressA:  press_a <= pwdata_i[47:0];
          RegPressB:  press_b <= pwdata_i[47:0];
          RegOss:     oss <= pwdata_i[1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) expected_q.push_back(compensate(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("result transaction with nothing expected");
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_q.pop_front();
          if (want != out_data_i) fail_count_o <= fail_count_o + 1;
          if (want.result_kind != out_data_i.result_kind)
            $error("result_kind expected %0d got %0d", want.result_kind,
                   out_data_i.result_kind);
          if (want.value != out_data_i.value)
            $error("value expected %0d got %0d", $signed(want.value),
                   $signed(out_data_i.value));
          if (want.divide_error != out_data_i.divide_error)
            $error("divide_error expected %0d got %0d", want.divide_error,
                   out_data_i.divide_error);
        end
      end
    end
  end
endmodule

// ===== test/tb_barometric_sensor_compensation_top.sv =====
// stimulus and verdict for the barometric compensation block
`timescale 1ns / 1ps
module tb_barometric_sensor_compensation_top;
  import bsc_pkg::*;

  localparam longint CycleLimit = 2000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  bsc_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  bsc_out_t    out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;
  longint      cycle_count = 0;
  bit          long_hold = 1'b0;

  always #5 clk_i = ~clk_i;

  barometric_sensor_compensation_top u_top (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  bsc_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_data_i(out_data),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .pready_i(pready),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 4);
  endfunction

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: random back-pressure, plus one long hold-off when asked
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (600) @(posedge clk_i);
        long_hold = 1'b0;
      end
      n = (cycle_count < 20000) ? 0 : gap_len();
      if ($urandom_range(0, 1) == 0 && n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_ready <= 1'b1;
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [63:0] data);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 3'b000}; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // valid stays high between back-to-back transactions and drops for a gap
  task automatic send(logic op, logic [18:0] raw, bit gaps);
    int n;
    n = gaps ? gap_len() : 0;
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= '{operation: op, raw_sample: raw};
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  // calibration near the datasheet example, with random perturbation
  task automatic load_typical();
    reg_write(RegTempCal, {16'd2868, 16'hD4BD, 16'd23153, 16'd32757} ^
              {$urandom_range(0, 255), $urandom_range(0, 255)} );
    reg_write(RegPressA,
              64'({16'hC7A2, 16'hFBC8, 16'd408} ^ 48'($urandom_range(0, 63))));
    reg_write(RegPressB,
              64'({16'd4, 16'd6190, 16'd32741} ^ 48'($urandom_range(0, 63))));
    reg_write(RegOss, 64'($urandom_range(0, 3)));
  endtask

  initial begin
    int k;
    logic op;
    logic [18:0] raw;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    // pressure before any temperature, reset calibration gives a zero divisor
    send(OpPress, 19'd0, 1'b0);
    send(OpTemp, 19'h7FFFF, 1'b0);
    drain();
    reg_write(RegTempCal, {16'd2868, 16'hD4BD, 16'd23153, 16'd32757});
    reg_write(RegPressA, 64'({16'hC7A2, 16'hFBC8, 16'd408}));
    reg_write(RegPressB, 64'({16'd4, 16'd6190, 16'd32741}));
    reg_write(RegOss, 64'd0);
    send(OpTemp, 19'd27898, 1'b0);
    send(OpPress, 19'd23843, 1'b0);
    send(OpTemp, 19'd0, 1'b0);
    send(OpPress, 19'h7FFFF, 1'b0);
    send(OpPress, 19'd0, 1'b0);
    drain();
    // zero temperature divisor: ac5 = 0 and md = 0 keeps the old b5
    reg_write(RegTempCal, {16'd0, 16'h8000, 16'hFFFF, 16'd0});
    send(OpTemp, 19'd1234, 1'b0);
    send(OpPress, 19'd40000, 1'b0);
    drain();
    // extreme calibration words
    reg_write(RegTempCal, 64'hFFFF_FFFF_FFFF_FFFF);
    reg_write(RegPressA, 64'h0000_8000_7FFF_FFFF);
    reg_write(RegPressB, 64'h0000_7FFF_8000_FFFF);
    reg_write(RegOss, 64'd3);
    send(OpTemp, 19'h55555, 1'b0);
    send(OpPress, 19'h2AAAA, 1'b0);
    send(OpTemp, 19'h7FFFF, 1'b0);
    send(OpPress, 19'h7FFFF, 1'b0);
    drain();
    // zero pressure divisor with ac4 = 0
    reg_write(RegPressB, 64'h0);
    send(OpPress, 19'd5000, 1'b0);
    drain();
    reg_write(RegTempCal, 64'h0);
    reg_write(RegPressA, 64'h0);
    reg_write(RegOss, 64'd1);
    send(OpTemp, 19'd9, 1'b0);
    send(OpPress, 19'd9, 1'b0);
    drain();
    // fill up against a long receiver hold-off
    load_typical();
    long_hold = 1'b1;
    repeat (20) send(1'($urandom_range(0, 1)), 19'($urandom), 1'b0);
    drain();
    for (k = 0; k < 1170; k++) begin
      if (k % 150 == 0) begin
        drain();
        case ($urandom_range(0, 3))
          0: begin
            reg_write(RegTempCal, {$urandom, $urandom});
            reg_write(RegPressA, 64'(48'({$urandom, $urandom})));
            reg_write(RegPressB, 64'(48'({$urandom, $urandom})));
            reg_write(RegOss, 64'($urandom_range(0, 3)));
          end
          default: load_typical();
        endcase
      end
      op = (k % 3 == 0) ? OpTemp : 1'($urandom_range(0, 1));
      case ($urandom_range(0, 4))
        0: raw = 19'($urandom);
        1: raw = 19'($urandom_range(0, 15)) | (19'($urandom_range(0, 1)) << 18);
        default: raw = op == OpTemp ? 19'($urandom_range(20000, 40000))
                                    : 19'($urandom_range(15000, 90000));
      endcase
      send(op, raw, 1'b1);
    end
    drain();
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
